// ===== rtl/core/bphm_pkg.sv =====
// Package for the backlog pressure hysteresis monitor.
// Holds the report codes, register indexes and shared state types.
// No dependencies.
package bphm_pkg;

	localparam int unsigned RUN_MAX = 255;

	typedef enum logic [1:0] {
		KIND_NONE   = 2'd0,
		KIND_ENTER  = 2'd1,
		KIND_UPDATE = 2'd2,
		KIND_EXIT   = 2'd3
	} report_kind_t;

	typedef enum logic [1:0] {
		REG_ENTER_TICKS  = 2'd0,
		REG_EXIT_TICKS   = 2'd1,
		REG_REPORT_PER   = 2'd2,
		REG_JITTER_LIMIT = 2'd3
	} reg_index_t;

	localparam logic [7:0]  ENTER_TICKS_RST  = 8'd2;
	localparam logic [7:0]  EXIT_TICKS_RST   = 8'd3;
	localparam logic [7:0]  REPORT_PER_RST   = 8'd10;
	localparam logic [15:0] JITTER_LIMIT_RST = 16'd700;

	typedef struct packed {
		logic [7:0] enter_ticks;
		logic [7:0] exit_ticks;
		logic [7:0] report_period;
	} hyst_cfg_t;

	typedef struct packed {
		logic       pressured;
		logic [7:0] pressure_run;
		logic [7:0] clear_run;
		logic [7:0] countdown;
	} hyst_state_t;

endpackage

// ===== rtl/core/bphm_hyst.sv =====
// Next-state logic of the hysteresis counters and the report decimator.
// Depends on bphm_pkg.
module bphm_hyst (
	input  bphm_pkg::hyst_state_t  cur,
	input  bphm_pkg::hyst_cfg_t    cfg,
	input  logic                   pressure,
	input  logic                   delta_nz,
	output bphm_pkg::hyst_state_t  nxt,
	output bphm_pkg::report_kind_t kind
);
	import bphm_pkg::*;

	logic [7:0] pr_inc;
	logic [7:0] cr_inc;
	logic [7:0] cd_dec;

	assign pr_inc = (cur.pressure_run == 8'(RUN_MAX)) ? cur.pressure_run
		: cur.pressure_run + 8'd1;
	assign cr_inc = (cur.clear_run == 8'(RUN_MAX)) ? cur.clear_run
		: cur.clear_run + 8'd1;
	assign cd_dec = (cur.countdown != 8'd0) ? cur.countdown - 8'd1 : cur.countdown;

	always_comb begin
		nxt  = cur;
		kind = KIND_NONE;
		if (pressure) begin
			nxt.clear_run    = 8'd0;
			nxt.pressure_run = pr_inc;
			if (!cur.pressured && pr_inc >= cfg.enter_ticks) begin
				nxt.pressured = 1'b1;
				nxt.countdown = cfg.report_period;
				kind          = KIND_ENTER;
			end else if (cur.pressured) begin
				if (delta_nz || cd_dec == 8'd0) begin
					nxt.countdown = cfg.report_period;
					kind          = KIND_UPDATE;
				end else begin
					nxt.countdown = cd_dec;
				end
			end
		end else begin
			nxt.pressure_run = 8'd0;
			if (!cur.pressured) begin
				nxt.clear_run = 8'd0;
			end else if (cr_inc >= cfg.exit_ticks) begin
				nxt.pressured = 1'b0;
				nxt.clear_run = 8'd0;
				nxt.countdown = 8'd0;
				kind          = KIND_EXIT;
			end else begin
				nxt.clear_run = cr_inc;
			end
		end
	end

endmodule

// ===== rtl/core/backlog_pressure_hysteresis_monitor_top.sv =====
// Top level of the backlog pressure hysteresis monitor.
// Depends on bphm_pkg and bphm_hyst.
//
//  Channel  Handshake            Payload
//  in       in_valid, in_stall   dropped_total, missed_total, backlog_level,
//                                due_queue_depth, jitter_us
//  out      out_valid, out_stall report_kind, pressured, dropped_step, missed_step
//  cfg      cfg_we               cfg_index, cfg_data
//
// One item is accepted per cycle while in_stall is low, into the input register.
// The input register feeds one pass of delta, compare and counter logic into the
// result register, and the state updates as the item enters the result register.
// Reset clears the valid flags, the hysteresis state and the last totals, and loads the register defaults.
// A stall on the output holds the result register and, while it holds an item, the input register too.
module backlog_pressure_hysteresis_monitor_top #(
	parameter int unsigned COUNTER_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  bphm_pkg::reg_index_t   cfg_index,
	input  logic [15:0]            cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [31:0]            dropped_total,
	input  logic [31:0]            missed_total,
	input  logic [15:0]            backlog_level,
	input  logic [7:0]             due_queue_depth,
	input  logic [15:0]            jitter_us,
	output logic                   out_valid,
	input  logic                   out_stall,
	output bphm_pkg::report_kind_t report_kind,
	output logic                   pressured,
	output logic [31:0]            dropped_step,
	output logic [31:0]            missed_step
);
	import bphm_pkg::*;

	localparam int unsigned CW = (COUNTER_BITS < 32) ? COUNTER_BITS : 32;

	hyst_cfg_t   cfg_q;
	logic [15:0] jitter_limit_q;

	logic        valid_s1;
	logic [31:0] dropped_s1;
	logic [31:0] missed_s1;
	logic [15:0] backlog_s1;
	logic [7:0]  depth_s1;
	logic [15:0] jitter_s1;

	hyst_state_t  state_q;
	hyst_state_t  state_nxt;
	report_kind_t kind_nxt;
	logic [CW-1:0] last_dropped_q;
	logic [CW-1:0] last_missed_q;

	logic [CW-1:0] dropped_now;
	logic [CW-1:0] missed_now;
	logic [CW-1:0] dd;
	logic [CW-1:0] md;
	logic          delta_nz;
	logic          pressure;
	logic          advance;

	logic         out_valid_q;
	report_kind_t kind_q;
	logic         pressured_q;
	logic [31:0]  dropped_step_q;
	logic [31:0]  missed_step_q;

	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;

	assign dropped_now = dropped_s1[CW-1:0];
	assign missed_now  = missed_s1[CW-1:0];
	assign dd = (dropped_now >= last_dropped_q) ? dropped_now - last_dropped_q : dropped_now;
	assign md = (missed_now >= last_missed_q) ? missed_now - last_missed_q : missed_now;
	assign delta_nz = (dd != '0) || (md != '0);
	assign pressure = (backlog_s1 != 16'd0) || (depth_s1 != 8'd0) || delta_nz
		|| (jitter_s1 >= jitter_limit_q);

	bphm_hyst u_hyst (
		.cur      (state_q),
		.cfg      (cfg_q),
		.pressure (pressure),
		.delta_nz (delta_nz),
		.nxt      (state_nxt),
		.kind     (kind_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enter_ticks   <= ENTER_TICKS_RST;
			cfg_q.exit_ticks    <= EXIT_TICKS_RST;
			cfg_q.report_period <= REPORT_PER_RST;
			jitter_limit_q      <= JITTER_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ENTER_TICKS:  cfg_q.enter_ticks   <= cfg_data[7:0];
				REG_EXIT_TICKS:   cfg_q.exit_ticks    <= cfg_data[7:0];
				REG_REPORT_PER:   cfg_q.report_period <= cfg_data[7:0];
				REG_JITTER_LIMIT: jitter_limit_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			dropped_s1 <= dropped_total;
			missed_s1  <= missed_total;
			backlog_s1 <= backlog_level;
			depth_s1   <= due_queue_depth;
			jitter_s1  <= jitter_us;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= '0;
			last_dropped_q <= '0;
			last_missed_q  <= '0;
			out_valid_q    <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				state_q        <= state_nxt;
				last_dropped_q <= dropped_now;
				last_missed_q  <= missed_now;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			kind_q         <= kind_nxt;
			pressured_q    <= state_nxt.pressured;
			dropped_step_q <= 32'(dd);
			missed_step_q  <= 32'(md);
		end
	end

	assign out_valid    = out_valid_q;
	assign report_kind  = kind_q;
	assign pressured    = pressured_q;
	assign dropped_step = dropped_step_q;
	assign missed_step  = missed_step_q;

	a_enter_sets_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (kind_q == KIND_ENTER || kind_q == KIND_UPDATE) |-> pressured_q)
		else $error("Enter or update reported while not pressured.");

	a_exit_clears_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q == KIND_EXIT |-> !pressured_q)
		else $error("Exit reported while still pressured.");

	a_clear_run_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!state_q.pressured |-> state_q.clear_run == 8'd0 && state_q.countdown == 8'd0
		|| $past(state_q.pressured))
		else $error("Clear run or countdown left behind outside the pressured state.");

	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!(advance && valid_s1) |=> $stable(state_q))
		else $error("Hysteresis state changed without an item.");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q && $stable(kind_q) && $stable(pressured_q))
		else $error("Stalled result changed.");

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for backlog_pressure_hysteresis_monitor_top.
// A built-in predictor of the delta, pressure and hysteresis rules checks every result.
// Depends on bphm_pkg and the monitor RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bphm_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [31:0] dropped;
		logic [31:0] missed;
		logic [15:0] backlog;
		logic [7:0]  depth;
		logic [15:0] jitter;
	} health_snapshot_t;

	typedef struct packed {
		report_kind_t kind;
		logic         pressured;
		logic [31:0]  dropped_step;
		logic [31:0]  missed_step;
	} monitor_report_t;

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	reg_index_t             cfg_index = REG_ENTER_TICKS;
	logic [15:0]            cfg_data = '0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic [31:0]            dropped_total = '0;
	logic [31:0]            missed_total = '0;
	logic [15:0]            backlog_level = '0;
	logic [7:0]             due_queue_depth = '0;
	logic [15:0]            jitter_us = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	report_kind_t           report_kind;
	logic                   pressured;
	logic [31:0]            dropped_step;
	logic [31:0]            missed_step;

	logic [7:0]  cfg_enter = ENTER_TICKS_RST;
	logic [7:0]  cfg_exit = EXIT_TICKS_RST;
	logic [7:0]  cfg_period = REPORT_PER_RST;
	logic [15:0] cfg_limit = JITTER_LIMIT_RST;

	logic        mon_pressured = 1'b0;
	logic [7:0]  mon_pressure_run = '0;
	logic [7:0]  mon_clear_run = '0;
	logic [7:0]  mon_countdown = '0;
	logic [31:0] mon_last_dropped = '0;
	logic [31:0] mon_last_missed = '0;

	monitor_report_t pending_reports[$];
	int unsigned     mismatch_count = 0;
	int unsigned     cycle_count = 0;
	int              burst_left = 0;

	backlog_pressure_hysteresis_monitor_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.dropped_total(dropped_total),
		.missed_total(missed_total),
		.backlog_level(backlog_level),
		.due_queue_depth(due_queue_depth),
		.jitter_us(jitter_us),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.report_kind(report_kind),
		.pressured(pressured),
		.dropped_step(dropped_step),
		.missed_step(missed_step)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic monitor_report_t predict_report(input health_snapshot_t s);
		logic [31:0]     d_step;
		logic [31:0]     m_step;
		logic            hot;
		monitor_report_t r;
		d_step = (s.dropped >= mon_last_dropped) ? s.dropped - mon_last_dropped : s.dropped;
		m_step = (s.missed >= mon_last_missed) ? s.missed - mon_last_missed : s.missed;
		mon_last_dropped = s.dropped;
		mon_last_missed = s.missed;
		hot = (s.backlog != 0) || (s.depth != 0) || (d_step != 0) || (m_step != 0)
			|| (s.jitter >= cfg_limit);
		r.kind = KIND_NONE;
		if (hot) begin
			mon_clear_run = '0;
			if (mon_pressure_run != 8'(RUN_MAX))
				mon_pressure_run++;
			if (!mon_pressured && mon_pressure_run >= cfg_enter) begin
				mon_pressured = 1'b1;
				mon_countdown = cfg_period;
				r.kind = KIND_ENTER;
			end else if (mon_pressured) begin
				if (mon_countdown != 0)
					mon_countdown--;
				if (d_step != 0 || m_step != 0 || mon_countdown == 0) begin
					mon_countdown = cfg_period;
					r.kind = KIND_UPDATE;
				end
			end
		end else begin
			mon_pressure_run = '0;
			if (!mon_pressured) begin
				mon_clear_run = '0;
			end else begin
				if (mon_clear_run != 8'(RUN_MAX))
					mon_clear_run++;
				if (mon_clear_run >= cfg_exit) begin
					mon_pressured = 1'b0;
					mon_clear_run = '0;
					mon_countdown = '0;
					r.kind = KIND_EXIT;
				end
			end
		end
		r.pressured = mon_pressured;
		r.dropped_step = d_step;
		r.missed_step = m_step;
		return r;
	endfunction

	always @(posedge clk) begin
		monitor_report_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_reports.size() == 0) begin
				$error("result with no item outstanding");
				mismatch_count++;
			end else begin
				exp_r = pending_reports.pop_front();
				if (report_kind !== exp_r.kind) begin
					$error("report_kind: expected %0d, got %0d", exp_r.kind, report_kind);
					mismatch_count++;
				end
				if (pressured !== exp_r.pressured) begin
					$error("pressured: expected %0d, got %0d", exp_r.pressured, pressured);
					mismatch_count++;
				end
				if (dropped_step !== exp_r.dropped_step) begin
					$error("dropped_step: expected %0h, got %0h", exp_r.dropped_step,
						dropped_step);
					mismatch_count++;
				end
				if (missed_step !== exp_r.missed_step) begin
					$error("missed_step: expected %0h, got %0h", exp_r.missed_step,
						missed_step);
					mismatch_count++;
				end
			end
		end
	end

	// Output stalls: mostly short, sometimes long, with stall-free stretches.
	initial begin
		int hold;
		int quiet;
		hold = 0;
		quiet = 0;
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				out_stall <= 1'b1;
				hold--;
			end else if (quiet > 0) begin
				out_stall <= 1'b0;
				quiet--;
			end else begin
				case ($urandom_range(9, 0))
					0: begin
						quiet = $urandom_range(60, 20);
						out_stall <= 1'b0;
					end
					1: begin
						hold = $urandom_range(40, 8);
						out_stall <= 1'b1;
					end
					2, 3, 4: begin
						hold = $urandom_range(2, 0);
						out_stall <= 1'b1;
					end
					default: out_stall <= 1'b0;
				endcase
			end
		end
	end

	function automatic int pick_gap();
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		case ($urandom_range(19, 0))
			0: begin
				burst_left = $urandom_range(40, 15);
				return 0;
			end
			1: return $urandom_range(30, 8);
			2, 3, 4, 5, 6, 7: return $urandom_range(3, 1);
			default: return 0;
		endcase
	endfunction

	task automatic send_snapshot(input health_snapshot_t s);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		dropped_total <= s.dropped;
		missed_total <= s.missed;
		backlog_level <= s.backlog;
		due_queue_depth <= s.depth;
		jitter_us <= s.jitter;
		do @(posedge clk); while (in_stall);
		pending_reports.push_back(predict_report(s));
	endtask

	task automatic drain_reports();
		in_valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_config(input logic [15:0] enter_v, input logic [15:0] exit_v,
			input logic [15:0] period_v, input logic [15:0] limit_v);
		logic [15:0] vals[4];
		vals[0] = enter_v;
		vals[1] = exit_v;
		vals[2] = period_v;
		vals[3] = limit_v;
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= reg_index_t'(i);
			cfg_data <= vals[i];
			@(posedge clk);
			case (reg_index_t'(i))
				REG_ENTER_TICKS:  cfg_enter = vals[i][7:0];
				REG_EXIT_TICKS:   cfg_exit = vals[i][7:0];
				REG_REPORT_PER:   cfg_period = vals[i][7:0];
				REG_JITTER_LIMIT: cfg_limit = vals[i];
			endcase
		end
		cfg_we <= 1'b0;
	endtask

	function automatic health_snapshot_t snapshot_of(input logic [31:0] d,
			input logic [31:0] m, input logic [15:0] b, input logic [7:0] q,
			input logic [15:0] j);
		health_snapshot_t s;
		s.dropped = d;
		s.missed = m;
		s.backlog = b;
		s.depth = q;
		s.jitter = j;
		return s;
	endfunction

	function automatic logic [31:0] bump_total(input logic [31:0] x);
		case ($urandom_range(7, 0))
			0: return $urandom();
			1: return (x != 0) ? 32'($urandom_range(x - 1, 0)) : x + 1;
			default: return x + 32'($urandom_range(5, 1));
		endcase
	endfunction

	// Unless fully random (one in eight), a clear snapshot repeats the last totals; a hot one adds one or more causes.
	function automatic health_snapshot_t make_snapshot(input bit hot);
		health_snapshot_t s;
		int               causes;
		if ($urandom_range(7, 0) == 0) begin
			s.dropped = $urandom();
			s.missed = $urandom();
			s.backlog = 16'($urandom());
			s.depth = 8'($urandom());
			s.jitter = 16'($urandom());
			return s;
		end
		s.dropped = mon_last_dropped;
		s.missed = mon_last_missed;
		s.backlog = '0;
		s.depth = '0;
		s.jitter = (cfg_limit == 0) ? 16'd0 : 16'($urandom_range(cfg_limit - 1, 0));
		if (hot) begin
			causes = $urandom_range(2, 1);
			repeat (causes) begin
				case ($urandom_range(7, 0))
					0, 1: s.backlog = 16'($urandom_range(65535, 1));
					2, 3: s.depth = 8'($urandom_range(255, 1));
					4: s.dropped = bump_total(mon_last_dropped);
					5: s.missed = bump_total(mon_last_missed);
					default: s.jitter = 16'($urandom_range(65535, cfg_limit));
				endcase
			end
		end
		return s;
	endfunction

	task automatic run_pressure_runs(input int count, input int max_run);
		bit hot;
		int run_left;
		hot = $urandom_range(1, 0);
		run_left = $urandom_range(max_run, 1);
		repeat (count) begin
			if (run_left == 0) begin
				hot = !hot;
				run_left = $urandom_range(max_run, 1);
			end
			send_snapshot(make_snapshot(hot));
			run_left--;
		end
	endtask

	function automatic logic [15:0] pick_run_reg();
		case ($urandom_range(3, 0))
			0: return 16'd0;
			1: return 16'd255;
			default: return 16'($urandom_range(12, 1));
		endcase
	endfunction

	task automatic test_default_thresholds();
		send_snapshot(snapshot_of(0, 0, 0, 0, 0));
		send_snapshot(snapshot_of(0, 0, 1, 0, 0));
		send_snapshot(snapshot_of(0, 0, 0, 255, 0));
		send_snapshot(snapshot_of(0, 0, 0, 0, 700));
		send_snapshot(snapshot_of(0, 0, 0, 0, 699));
		send_snapshot(snapshot_of(32'hFFFF_FFFF, 0, 0, 0, 0));
		send_snapshot(snapshot_of(5, 0, 0, 0, 0));
		send_snapshot(snapshot_of(5, 32'hFFFF_FFFF, 0, 0, 0));
		send_snapshot(snapshot_of(5, 0, 0, 0, 0));
		send_snapshot(snapshot_of(5, 0, 16'hFFFF, 0, 16'hFFFF));
		repeat (3) send_snapshot(snapshot_of(5, 0, 0, 0, 0));
		drain_reports();
	endtask

	task automatic test_config_extremes();
		set_config(0, 0, 0, 0);
		repeat (3) send_snapshot(snapshot_of(5, 0, 0, 0, 0));
		drain_reports();
		set_config(0, 0, 0, 16'hFFFF);
		send_snapshot(snapshot_of(5, 0, 0, 0, 16'hFFFE));
		send_snapshot(snapshot_of(5, 0, 0, 0, 16'hFFFF));
		send_snapshot(snapshot_of(5, 0, 0, 1, 0));
		send_snapshot(snapshot_of(5, 0, 0, 0, 0));
		drain_reports();
		set_config(1, 2, 2, 700);
		repeat (5) send_snapshot(snapshot_of(5, 0, 1, 0, 0));
		repeat (2) send_snapshot(snapshot_of(5, 0, 0, 0, 0));
		drain_reports();
	endtask

	task automatic test_random_defaults();
		set_config(16'(ENTER_TICKS_RST), 16'(EXIT_TICKS_RST), 16'(REPORT_PER_RST),
			JITTER_LIMIT_RST);
		run_pressure_runs(40, 14);
		drain_reports();
	endtask

	task automatic test_random_tight();
		set_config(1, 1, 1, 16'($urandom_range(2000, 1)));
		run_pressure_runs(60, 4);
		drain_reports();
	endtask

	task automatic test_random_configs();
		logic [15:0] limit_v;
		repeat (4) begin
			case ($urandom_range(3, 0))
				0: limit_v = 16'd0;
				1: limit_v = 16'hFFFF;
				default: limit_v = 16'($urandom_range(2000, 200));
			endcase
			set_config(pick_run_reg(), pick_run_reg(), pick_run_reg(), limit_v);
			run_pressure_runs(20, 20);
			drain_reports();
		end
	endtask

	// Entry at the largest threshold takes 255 pressured items in a row.
	task automatic test_slowest_entry();
		set_config(16'h5AFF, 16'h00FF, 16'h00FF, 16'hFFFF);
		repeat (260) send_snapshot(make_snapshot(1'b1));
		repeat (5) send_snapshot(make_snapshot(1'b0));
		drain_reports();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_default_thresholds();
		test_config_extremes();
		test_random_defaults();
		test_random_tight();
		test_random_configs();
		test_slowest_entry();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && pending_reports.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
